[hw/rtl/websocket_frame_deframer_assert.svh]
// Assertion macros shared by the frame deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define WSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define WSFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSFD_ASSERT(lbl, prop, msg)
`define WSFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/wsfd_pkg.sv]
// Shared types, constants and helpers for the frame deframer.
package wsfd_pkg;

  localparam int unsigned MAX_PAYLOAD_W = 21;
  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 21'd65536;

  localparam logic [2:0] KIND_TEXT   = 3'd0;
  localparam logic [2:0] KIND_BINARY = 3'd1;
  localparam logic [2:0] KIND_PING   = 3'd2;
  localparam logic [2:0] KIND_CLOSE  = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic CAUSE_UNMASKED  = 1'b0;
  localparam logic CAUSE_TOO_LONG  = 1'b1;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [2:0] kind;
    logic       error_cause;
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       deliver;
    logic [2:0] kind;
  } data_kind_t;

  function automatic data_kind_t data_kind(input logic [3:0] op);
    data_kind_t dk;
    dk.deliver = 1'b1;
    dk.kind    = KIND_TEXT;
    case (op)
      OP_TEXT:   dk.kind = KIND_TEXT;
      OP_BINARY: dk.kind = KIND_BINARY;
      OP_PING:   dk.kind = KIND_PING;
      default:   dk.deliver = 1'b0;
    endcase
    return dk;
  endfunction

endpackage

[hw/rtl/wsfd_parser.sv]
// Frame header, length, mask key and payload parser: one byte per step.
`include "websocket_frame_deframer_assert.svh"
module wsfd_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wsfd_pkg::MAX_PAYLOAD_W-1:0] cfg_data,
  input  logic                               step,
  input  logic [7:0]                         rx_byte,
  output logic                               res_vld,
  output wsfd_pkg::res_t                     res
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD, PH_HALT
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [3:0]               opcode_r, opcode_nxt;
  logic                     mask_seen_r, mask_seen_nxt;
  logic [3:0]               left_r, left_nxt;
  logic [63:0]              rem_r, rem_nxt;
  logic [31:0]              key_r, key_nxt;
  logic [1:0]               pos_r, pos_nxt;
  logic [MAX_PAYLOAD_W-1:0] max_r;

  data_kind_t dk;
  logic       too_long;
  logic       fin;
  logic [7:0] key_byte;

  assign dk       = data_kind(opcode_r);
  assign too_long = (|rem_r[63:MAX_PAYLOAD_W]) || (rem_r[MAX_PAYLOAD_W-1:0] > max_r);
  assign fin      = (rem_r == 64'd1);

  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    opcode_nxt    = opcode_r;
    mask_seen_nxt = mask_seen_r;
    left_nxt      = left_r;
    rem_nxt       = rem_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    res_vld       = 1'b0;
    res           = '0;
    if (step) begin
      case (phase_r)
        PH_HDR0: begin
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_seen_nxt = rx_byte[7];
          rem_nxt       = '0;
          if (rx_byte[6:0] == LEN_EXT16) begin
            left_nxt  = 4'd2;
            phase_nxt = PH_EXTLEN;
          end else if (rx_byte[6:0] == LEN_EXT64) begin
            left_nxt  = 4'd8;
            phase_nxt = PH_EXTLEN;
          end else begin
            rem_nxt = {57'd0, rx_byte[6:0]};
            if (!rx_byte[7]) begin
              res_vld         = 1'b1;
              res.kind        = KIND_ERROR;
              res.error_cause = CAUSE_UNMASKED;
              res.last        = 1'b1;
              phase_nxt       = PH_HALT;
            end else begin
              pos_nxt   = '0;
              key_nxt   = '0;
              phase_nxt = PH_MASK;
            end
          end
        end
        PH_EXTLEN: begin
          rem_nxt  = {rem_r[55:0], rx_byte};
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            if (!mask_seen_r) begin
              res_vld         = 1'b1;
              res.kind        = KIND_ERROR;
              res.error_cause = CAUSE_UNMASKED;
              res.last        = 1'b1;
              phase_nxt       = PH_HALT;
            end else begin
              pos_nxt   = '0;
              key_nxt   = '0;
              phase_nxt = PH_MASK;
            end
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          pos_nxt = pos_r + 2'd1;
          if (pos_r == 2'd3) begin
            if (too_long) begin
              res_vld         = 1'b1;
              res.kind        = KIND_ERROR;
              res.error_cause = CAUSE_TOO_LONG;
              res.last        = 1'b1;
              phase_nxt       = PH_HALT;
            end else if (rem_r == 64'd0) begin
              phase_nxt = PH_HDR0;
              if (opcode_r == OP_CLOSE) begin
                res_vld   = 1'b1;
                res.kind  = KIND_CLOSE;
                res.last  = 1'b1;
                phase_nxt = PH_HALT;
              end else if (dk.deliver) begin
                res_vld  = 1'b1;
                res.kind = dk.kind;
                res.last = 1'b1;
              end
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          pos_nxt = pos_r + 2'd1;
          rem_nxt = rem_r - 64'd1;
          if (fin) begin
            phase_nxt = PH_HDR0;
          end
          if (opcode_r == OP_CLOSE) begin
            if (fin) begin
              res_vld   = 1'b1;
              res.kind  = KIND_CLOSE;
              res.last  = 1'b1;
              phase_nxt = PH_HALT;
            end
          end else if (dk.deliver) begin
            res_vld       = 1'b1;
            res.kind      = dk.kind;
            res.data_byte = rx_byte ^ key_byte;
            res.has_data  = 1'b1;
            res.last      = fin;
          end
        end
        default: begin
          phase_nxt = PH_HALT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      opcode_r    <= '0;
      mask_seen_r <= 1'b0;
      left_r      <= '0;
      rem_r       <= '0;
      key_r       <= '0;
      pos_r       <= '0;
      max_r       <= MAX_PAYLOAD_RST;
    end else begin
      phase_r     <= phase_nxt;
      opcode_r    <= opcode_nxt;
      mask_seen_r <= mask_seen_nxt;
      left_r      <= left_nxt;
      rem_r       <= rem_nxt;
      key_r       <= key_nxt;
      pos_r       <= pos_nxt;
      if (cfg_we) begin
        max_r <= cfg_data;
      end
    end
  end

  `WSFD_ASSERT(a_stop_after_final_event,
    res_vld && (res.kind == KIND_ERROR || res.kind == KIND_CLOSE) |=> phase_r == PH_HALT,
    "close or error item did not stop the parser")
  `WSFD_ASSERT(a_halt_is_silent, phase_r == PH_HALT |-> !res_vld,
    "item produced while stopped")
  `WSFD_ASSERT(a_data_only_in_payload, res_vld && res.has_data |-> phase_r == PH_PAYLOAD,
    "data item outside payload")

endmodule

[hw/rtl/wsfd_out_buf.sv]
// Two-entry output buffer between the parser and the result channel.
`include "websocket_frame_deframer_assert.svh"
module wsfd_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wsfd_pkg::res_t push_data,
  output logic           room,
  output logic           head_vld,
  output wsfd_pkg::res_t head,
  input  logic           pop_rdy
);
  import wsfd_pkg::*;

  logic h_v_r, h_v_nxt;
  logic t_v_r, t_v_nxt;
  res_t h_r, h_nxt;
  res_t t_r, t_nxt;
  logic pop;

  assign pop      = h_v_r && pop_rdy;
  assign room     = !t_v_r;
  assign head_vld = h_v_r;
  assign head     = h_r;

  always_comb begin
    h_v_nxt = h_v_r;
    t_v_nxt = t_v_r;
    h_nxt   = h_r;
    t_nxt   = t_r;
    if (pop) begin
      h_v_nxt = t_v_r;
      h_nxt   = t_r;
      t_v_nxt = 1'b0;
    end
    if (push) begin
      if (!h_v_nxt) begin
        h_v_nxt = 1'b1;
        h_nxt   = push_data;
      end else begin
        t_v_nxt = 1'b1;
        t_nxt   = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
      t_v_r <= 1'b0;
    end else begin
      h_v_r <= h_v_nxt;
      t_v_r <= t_v_nxt;
    end
    h_r <= h_nxt;
    t_r <= t_nxt;
  end

  `WSFD_ASSERT_ALWAYS(a_tail_needs_head, t_v_r |-> h_v_r,
    "tail entry held without a head entry")
  `WSFD_ASSERT(a_no_push_when_full, push |-> !t_v_r,
    "item pushed into a full buffer")
  `WSFD_ASSERT(a_push_behind_stalled_head, push && h_v_r && !pop |=> t_v_r,
    "item lost behind a stalled head")

endmodule

[hw/rtl/websocket_frame_deframer.sv]
// Top level of the byte-serial WebSocket client frame deframer.
// Usage:
//   in_valid/in_ready/in_rx_byte: one byte of the client-to-server stream per item.
//   out_valid/out_ready/out_*: result items (payload bytes, close, error events).
//   cfg_valid/cfg_ready/cfg_data: writes max_payload; write only while idle.
// Results: a result is registered in the output buffer before it appears on
//   out_*. Bytes that cause no result simply update the parser state.
// Throughput: one byte per cycle while in_ready is high: while the two-entry output
//   buffer has a free entry, so one stalled result does not hold up the input;
//   with out_ready low for two results, input is held until one is taken.
// Reset (rst_n low, synchronous): parser expects a first header byte,
//   max_payload returns to 65536 and the output buffer empties; in_ready and
//   cfg_ready are low while rst_n is low.
// After a close or an error result the block ignores all further bytes
//   (still accepting them) until the next reset.
module websocket_frame_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_kind,
  output logic                               out_error_cause,
  output logic [7:0]                         out_data_byte,
  output logic                               out_has_data,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsfd_pkg::MAX_PAYLOAD_W-1:0] cfg_data
);
  import wsfd_pkg::*;

  logic step;
  logic res_vld;
  res_t res;
  res_t head;
  logic room;

  assign cfg_ready = rst_n;
  assign in_ready  = rst_n && room;
  assign step      = in_valid && in_ready;

  wsfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .step    (step),
    .rx_byte (in_rx_byte),
    .res_vld (res_vld),
    .res     (res)
  );

  wsfd_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_vld),
    .push_data(res),
    .room     (room),
    .head_vld (out_valid),
    .head     (head),
    .pop_rdy  (out_ready)
  );

  assign out_kind        = head.kind;
  assign out_error_cause = head.error_cause;
  assign out_data_byte   = head.data_byte;
  assign out_has_data    = head.has_data;
  assign out_last        = head.last;

endmodule
